[rtl/hsv_multi_range_pixel_classifier_macros.svh]
// Assertion macros shared by the classifier checker.
`ifndef HSV_MULTI_RANGE_PIXEL_CLASSIFIER_MACROS_SVH
`define HSV_MULTI_RANGE_PIXEL_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HMRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmrc check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HMRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmrc check failed");

`endif

[rtl/hmrc_pkg.sv]
// Shared types and constants of the HSV range classifier.
package hmrc_pkg;

	// Fixed field widths
	localparam int BOX_LIM     = 4;
	localparam int BOX_IDX_W   = 2;
	localparam int PICK_W      = 3;
	localparam int CNT_W       = 25;
	localparam int ROW_W       = 13;
	localparam int ROWCNT_W    = 12;
	localparam int COL_W       = 16;
	localparam int BOUNDS_W    = 60;
	localparam int COMP_PORT_W = 10;
	localparam int RNG_W       = 3;
	localparam int IDX_W       = 3;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [ROW_W-1:0] MAX_ROWS  = 13'd4096;
	localparam logic [COL_W-1:0] COL_LIMIT = 16'd65534;

	// Result kinds
	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_COL_HEIGHT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_CHECK_VALUE = 3'd1;
	localparam logic [IDX_W-1:0] REG_RANGE_COUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOX0_BOUNDS = 3'd3;

	typedef struct packed {
		logic [ROW_W-1:0] col_height;
		logic             check_value;
		logic [RNG_W-1:0] range_count;
	} cfg_t;

	// One classified pixel waiting for the back end
	typedef struct packed {
		logic [BOX_LIM-1:0]            hit;
		logic [BOX_LIM-1:0]            sum;
		logic [ROW_W-1:0]              row;
		logic [COL_W-1:0]              col;
		logic [BOX_LIM-1:0][CNT_W-1:0] counts;
		logic [CNT_W-1:0]              total;
	} job_t;

endpackage

[rtl/hmrc_queue.sv]
// Two-entry job queue between the classifier front and back ends.
module hmrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmrc_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output hmrc_pkg::job_t  head_job
);

	hmrc_pkg::job_t                  entry_q [hmrc_pkg::QDEPTH];
	logic [hmrc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hmrc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hmrc_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == hmrc_pkg::QCNT_W'(hmrc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/hmrc_front.sv]
// Front end: box tests, coordinate and count tracking, job build.
module hmrc_front #(
	parameter int MAX_BOXES        = 4,
	parameter int COMPONENT_BITS   = 10,
	parameter int MAX_FRAME_PIXELS = 16777216
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  hmrc_pkg::cfg_t                                cfg,
	input  logic [MAX_BOXES-1:0][hmrc_pkg::BOUNDS_W-1:0]  bounds,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]              hue,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]              saturation,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]              brightness,
	input  logic                                          frame_end,
	input  logic                                          accept,
	output hmrc_pkg::job_t                                job
);

	localparam logic [hmrc_pkg::CNT_W-1:0] SAT_CNT = hmrc_pkg::CNT_W'(MAX_FRAME_PIXELS);

	logic [COMPONENT_BITS-1:0]               h;
	logic [COMPONENT_BITS-1:0]               s;
	logic [COMPONENT_BITS-1:0]               v;
	logic [hmrc_pkg::ROW_W-1:0]              width_eff;
	logic [hmrc_pkg::RNG_W-1:0]              boxes_eff;
	logic [MAX_BOXES-1:0]                    active;
	logic [MAX_BOXES-1:0]                    hit;
	logic [hmrc_pkg::ROWCNT_W-1:0]           row_q;
	logic [hmrc_pkg::COL_W-1:0]              col_q;
	logic [hmrc_pkg::CNT_W-1:0]              pix_q;
	logic [MAX_BOXES-1:0][hmrc_pkg::CNT_W-1:0] cnt_q;
	logic [MAX_BOXES-1:0][hmrc_pkg::CNT_W-1:0] cnt_nxt;
	logic [hmrc_pkg::CNT_W-1:0]              pix_nxt;
	logic [hmrc_pkg::ROW_W-1:0]              row_p1;

	assign h = hue[COMPONENT_BITS-1:0];
	assign s = saturation[COMPONENT_BITS-1:0];
	assign v = brightness[COMPONENT_BITS-1:0];

	// Clamp the column height and box count
	always_comb begin
		if (cfg.col_height == '0) begin
			width_eff = hmrc_pkg::ROW_W'(1);
		end else if (cfg.col_height > hmrc_pkg::MAX_ROWS) begin
			width_eff = hmrc_pkg::MAX_ROWS;
		end else begin
			width_eff = cfg.col_height;
		end
		if (cfg.range_count > hmrc_pkg::RNG_W'(MAX_BOXES)) begin
			boxes_eff = hmrc_pkg::RNG_W'(MAX_BOXES);
		end else begin
			boxes_eff = cfg.range_count;
		end
	end

	// Test the pixel against each box
	for (genvar b = 0; b < MAX_BOXES; b++) begin : g_box
		logic [COMPONENT_BITS-1:0] lo_h, hi_h, lo_s, hi_s, lo_v, hi_v;
		assign lo_h = bounds[b][5*COMPONENT_BITS +: COMPONENT_BITS];
		assign hi_h = bounds[b][4*COMPONENT_BITS +: COMPONENT_BITS];
		assign lo_s = bounds[b][3*COMPONENT_BITS +: COMPONENT_BITS];
		assign hi_s = bounds[b][2*COMPONENT_BITS +: COMPONENT_BITS];
		assign lo_v = bounds[b][1*COMPONENT_BITS +: COMPONENT_BITS];
		assign hi_v = bounds[b][0 +: COMPONENT_BITS];
		assign active[b] = (hmrc_pkg::RNG_W'(b) < boxes_eff);
		assign hit[b] = active[b] && (lo_h <= h) && (h <= hi_h) &&
			(lo_s <= s) && (s <= hi_s) &&
			(!cfg.check_value || ((lo_v <= v) && (v <= hi_v)));
		assign cnt_nxt[b] = (hit[b] && (cnt_q[b] < SAT_CNT)) ?
			cnt_q[b] + 1'b1 : cnt_q[b];
	end

	assign pix_nxt = (pix_q < SAT_CNT) ? pix_q + 1'b1 : pix_q;
	assign row_p1  = {1'b0, row_q} + 1'b1;

	// Build the job, padding lanes past the configured box limit
	for (genvar i = 0; i < hmrc_pkg::BOX_LIM; i++) begin : g_lane
		if (i < MAX_BOXES) begin : g_used
			assign job.hit[i]    = hit[i];
			assign job.sum[i]    = frame_end && active[i];
			assign job.counts[i] = cnt_nxt[i];
		end else begin : g_unused
			assign job.hit[i]    = 1'b0;
			assign job.sum[i]    = 1'b0;
			assign job.counts[i] = '0;
		end
	end
	assign job.row   = row_p1;
	assign job.col   = col_q + 1'b1;
	assign job.total = pix_nxt;

	// Advance coordinates and counts; clear them on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pix_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				row_q <= '0;
				col_q <= '0;
				pix_q <= '0;
				cnt_q <= '0;
			end else begin
				pix_q <= pix_nxt;
				cnt_q <= cnt_nxt;
				if (row_p1 >= width_eff) begin
					row_q <= '0;
					if (col_q < hmrc_pkg::COL_LIMIT) begin
						col_q <= col_q + 1'b1;
					end
				end else begin
					row_q <= row_p1[hmrc_pkg::ROWCNT_W-1:0];
				end
			end
		end
	end

endmodule

[rtl/hmrc_back.sv]
// Back end: walks each job's hits and summaries, one result per cycle while out_stall is low.
module hmrc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  hmrc_pkg::job_t                head_job,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [hmrc_pkg::BOX_IDX_W-1:0] box_index,
	output logic [hmrc_pkg::ROW_W-1:0]    row_pos,
	output logic [hmrc_pkg::COL_W-1:0]    col_pos,
	output logic [hmrc_pkg::CNT_W-1:0]    match_count,
	output logic [hmrc_pkg::CNT_W-1:0]    pixel_total,
	output logic                          last
);

	localparam int PEND_W = 2 * hmrc_pkg::BOX_LIM;

	logic [PEND_W-1:0]           rem_q;
	logic                        started_q;
	logic [PEND_W-1:0]           cur;
	logic [PEND_W-1:0]           low_one;
	logic [PEND_W-1:0]           rem_nxt;
	logic [hmrc_pkg::PICK_W-1:0] pick;
	logic                        out_free;
	logic                        load;
	logic                        valid_q;
	logic                        kind_q;
	logic [hmrc_pkg::BOX_IDX_W-1:0] box_q;
	logic [hmrc_pkg::ROW_W-1:0]  row_q;
	logic [hmrc_pkg::COL_W-1:0]  col_q;
	logic [hmrc_pkg::CNT_W-1:0]  cnt_q;
	logic [hmrc_pkg::CNT_W-1:0]  tot_q;
	logic                        last_q;

	// Pick the lowest pending result: hits first, then summaries
	always_comb begin
		cur     = started_q ? rem_q : {head_job.sum, head_job.hit};
		low_one = cur & (~cur + 1'b1);
		rem_nxt = cur & ~low_one;
		pick    = '0;
		for (int i = PEND_W - 1; i >= 0; i--) begin
			if (cur[i]) begin
				pick = hmrc_pkg::PICK_W'(i);
			end
		end
	end

	assign out_free = !valid_q || !out_stall;
	assign load     = head_valid && (cur != '0) && out_free;
	assign pop      = head_valid && ((cur == '0) || (load && (rem_nxt == '0)));

	// Track progress through the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			rem_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				started_q <= 1'b0;
			end else if (load) begin
				started_q <= 1'b1;
			end
			if (load) begin
				rem_q <= rem_nxt;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= pick[hmrc_pkg::PICK_W-1];
			box_q  <= pick[hmrc_pkg::BOX_IDX_W-1:0];
			last_q <= (rem_nxt == '0);
			if (pick[hmrc_pkg::PICK_W-1] == hmrc_pkg::KIND_SUMMARY) begin
				row_q <= '0;
				col_q <= '0;
				cnt_q <= head_job.counts[pick[hmrc_pkg::BOX_IDX_W-1:0]];
				tot_q <= head_job.total;
			end else begin
				row_q <= head_job.row;
				col_q <= head_job.col;
				cnt_q <= '0;
				tot_q <= '0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign box_index   = box_q;
	assign row_pos     = row_q;
	assign col_pos     = col_q;
	assign match_count = cnt_q;
	assign pixel_total = tot_q;
	assign last        = last_q;

endmodule

[rtl/hsv_multi_range_pixel_classifier.sv]
// HSV multi-range pixel classifier, top level.
//
// Pixels arrive on the in_valid/in_stall channel in column-major order, one
// request per pixel, with frame_end on the frame's last pixel. Each pixel is
// tested against up to four inclusive HSV boxes. For every matching box a
// match result with 1-based row and column leaves on out_valid/out_stall;
// on frame end one summary per box in use follows, with the box's match
// count and the frame's pixel count, and all counters clear. last marks the
// final result of a pixel; a pixel that matches nothing and does not end a
// frame gives no result.
// The first result of a pixel is registered in the job queue and then in the
// output register. The back end sends one result per cycle while out_stall
// is low; pixels with at most one result stream at one per cycle while
// out_stall is low. A two-entry job queue between front and back sets the slack.
// Reset clears counters, the queue and the output valid flag and loads the
// registers with width 1, value check on, one box, all bounds zero.
// While out_stall is high the output holds; once the queue fills, in_stall
// rises until the back end drains a job.
module hsv_multi_range_pixel_classifier #(
	parameter int MAX_BOXES        = 4,
	parameter int COMPONENT_BITS   = 10,
	parameter int MAX_FRAME_PIXELS = 16777216
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hmrc_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [hmrc_pkg::BOUNDS_W-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]    hue,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]    saturation,
	input  logic [hmrc_pkg::COMP_PORT_W-1:0]    brightness,
	input  logic                                frame_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic [hmrc_pkg::BOX_IDX_W-1:0]      box_index,
	output logic [hmrc_pkg::ROW_W-1:0]          row_pos,
	output logic [hmrc_pkg::COL_W-1:0]          col_pos,
	output logic [hmrc_pkg::CNT_W-1:0]          match_count,
	output logic [hmrc_pkg::CNT_W-1:0]          pixel_total,
	output logic                                last
);

	hmrc_pkg::cfg_t                                 cfg_q;
	logic [MAX_BOXES-1:0][hmrc_pkg::BOUNDS_W-1:0]   bounds_q;
	hmrc_pkg::job_t                                 push_job;
	hmrc_pkg::job_t                                 head_job;
	logic                                           q_full;
	logic                                           head_valid;
	logic                                           pop;
	logic                                           accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Scalar configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.col_height  <= hmrc_pkg::ROW_W'(1);
			cfg_q.check_value <= 1'b1;
			cfg_q.range_count <= hmrc_pkg::RNG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hmrc_pkg::REG_COL_HEIGHT:  cfg_q.col_height <= cfg_wdata[hmrc_pkg::ROW_W-1:0];
				hmrc_pkg::REG_CHECK_VALUE: cfg_q.check_value <= cfg_wdata[0];
				hmrc_pkg::REG_RANGE_COUNT: cfg_q.range_count <= cfg_wdata[hmrc_pkg::RNG_W-1:0];
				default: ;
			endcase
		end
	end

	// Box bound registers
	for (genvar b = 0; b < MAX_BOXES; b++) begin : g_bounds
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bounds_q[b] <= '0;
			end else if (cfg_we &&
					(cfg_idx == hmrc_pkg::IDX_W'(hmrc_pkg::REG_BOX0_BOUNDS + b))) begin
				bounds_q[b] <= cfg_wdata;
			end
		end
	end

	hmrc_front #(
		.MAX_BOXES        (MAX_BOXES),
		.COMPONENT_BITS   (COMPONENT_BITS),
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.bounds     (bounds_q),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.frame_end  (frame_end),
		.accept     (accept),
		.job        (push_job)
	);

	hmrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	hmrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.box_index   (box_index),
		.row_pos     (row_pos),
		.col_pos     (col_pos),
		.match_count (match_count),
		.pixel_total (pixel_total),
		.last        (last)
	);

endmodule

[rtl/hmrc_checker.sv]
// Port-level checker for the classifier and its bind.
`include "hsv_multi_range_pixel_classifier_macros.svh"

module hmrc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             kind,
	input logic [hmrc_pkg::ROW_W-1:0]       row_pos,
	input logic [hmrc_pkg::COL_W-1:0]       col_pos,
	input logic [hmrc_pkg::CNT_W-1:0]       match_count,
	input logic [hmrc_pkg::CNT_W-1:0]       pixel_total
);

	// A stalled result stays offered
	`HMRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// Match results carry coordinates and no counts
	`HMRC_ASSERT_NOW(a_match_fields, out_valid && (kind == hmrc_pkg::KIND_MATCH), (row_pos != '0) && (col_pos != '0) && (match_count == '0) && (pixel_total == '0))

	// Summaries carry no coordinates
	`HMRC_ASSERT_NOW(a_sum_coords, out_valid && (kind == hmrc_pkg::KIND_SUMMARY), (row_pos == '0) && (col_pos == '0))

	// A box never matches more pixels than the frame holds
	`HMRC_ASSERT_NOW(a_sum_bound, out_valid && (kind == hmrc_pkg::KIND_SUMMARY), (match_count <= pixel_total) && (pixel_total != '0))

endmodule

bind hsv_multi_range_pixel_classifier hmrc_checker u_hmrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.row_pos     (row_pos),
	.col_pos     (col_pos),
	.match_count (match_count),
	.pixel_total (pixel_total)
);

[sim/tb.sv]
// Self-checking testbench for the HSV multi-range pixel classifier.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOX_LIM     = hmrc_pkg::BOX_LIM;
	localparam int BOX_IDX_W   = hmrc_pkg::BOX_IDX_W;
	localparam int CNT_W       = hmrc_pkg::CNT_W;
	localparam int ROW_W       = hmrc_pkg::ROW_W;
	localparam int ROWCNT_W    = hmrc_pkg::ROWCNT_W;
	localparam int COL_W       = hmrc_pkg::COL_W;
	localparam int BOUNDS_W    = hmrc_pkg::BOUNDS_W;
	localparam int COMP_PORT_W = hmrc_pkg::COMP_PORT_W;
	localparam int RNG_W       = hmrc_pkg::RNG_W;
	localparam int IDX_W       = hmrc_pkg::IDX_W;

	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_AT       = 40;
	localparam int HOLD_LEN      = 400;
	localparam int PHASES        = 8;
	localparam int PHASE_PIXELS  = 30;
	localparam int FRAME_PIX_MAX = 16777216;
	localparam int COMP_MAX      = 1023;

	localparam logic [BOUNDS_W-1:0] FULL_BOX = {10'd0, 10'h3FF, 10'd0, 10'h3FF, 10'd0, 10'h3FF};

	typedef enum int {RX_FREE, RX_HALF, RX_LIGHT, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic [COMP_PORT_W-1:0] h;
		logic [COMP_PORT_W-1:0] s;
		logic [COMP_PORT_W-1:0] v;
		logic                   fend;
	} pixel_t;

	typedef struct packed {
		logic                 kind;
		logic [BOX_IDX_W-1:0] box;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		logic [CNT_W-1:0]     cnt;
		logic [CNT_W-1:0]     tot;
		logic                 last;
	} result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_we    = 1'b0;
	logic [IDX_W-1:0]       cfg_idx   = '0;
	logic [BOUNDS_W-1:0]    cfg_wdata = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [COMP_PORT_W-1:0] hue        = '0;
	logic [COMP_PORT_W-1:0] saturation = '0;
	logic [COMP_PORT_W-1:0] brightness = '0;
	logic                   frame_end  = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   kind;
	logic [BOX_IDX_W-1:0]   box_index;
	logic [ROW_W-1:0]       row_pos;
	logic [COL_W-1:0]       col_pos;
	logic [CNT_W-1:0]       match_count;
	logic [CNT_W-1:0]       pixel_total;
	logic                   last;

	// Shadow registers and counters of the classifier
	logic [ROW_W-1:0]    m_width = 13'd1;
	logic                m_check = 1'b1;
	logic [RNG_W-1:0]    m_range = 3'd1;
	logic [BOUNDS_W-1:0] m_bounds[BOX_LIM] = '{default: '0};
	logic [ROWCNT_W-1:0] row_cnt = '0;
	logic [COL_W-1:0]    col_cnt = '0;
	logic [CNT_W-1:0]    hit_cnt[BOX_LIM] = '{default: '0};
	logic [CNT_W-1:0]    px_cnt = '0;

	pixel_t  pixel_requests[$];
	result_t awaited_results[$];

	pixel_t   drv_px;
	int       burst_left = 1;
	int       gap_left = 0;
	logic     in_taken = 1'b0;
	int       pixels_in = 0;
	int       errors = 0;
	int       quiet_cycles = 0;
	int       rx_cycle = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       hold_left = 0;
	logic     hold_done = 1'b0;
	result_t  got;
	result_t  want;

	hsv_multi_range_pixel_classifier dut (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_wdata,
		.in_valid, .in_stall, .hue, .saturation, .brightness, .frame_end,
		.out_valid, .out_stall, .kind, .box_index, .row_pos, .col_pos,
		.match_count, .pixel_total, .last
	);

	always #10 clk = ~clk;

	function automatic logic [COMP_PORT_W-1:0] bound_of(logic [BOUNDS_W-1:0] p, int slot);
		return p[(5 - slot) * COMP_PORT_W +: COMP_PORT_W];
	endfunction

	function automatic logic in_window(logic [COMP_PORT_W-1:0] x, logic [BOUNDS_W-1:0] p,
			int slot);
		return bound_of(p, slot) <= x && x <= bound_of(p, slot + 1);
	endfunction

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
		return (c < FRAME_PIX_MAX) ? c + 1'b1 : c;
	endfunction

	function automatic logic [BOUNDS_W-1:0] pack_box(int lh, int hh, int ls, int hs, int lv,
			int hv);
		return {10'(lh), 10'(hh), 10'(ls), 10'(hs), 10'(lv), 10'(hv)};
	endfunction

	function automatic string show(result_t r);
		return $sformatf("kind %0d box %0d row %0d col %0d count %0d total %0d last %0d",
			r.kind, r.box, r.row, r.col, r.cnt, r.tot, r.last);
	endfunction

	// Classify one pixel and queue the results it causes
	task automatic classify_pixel(input logic [COMP_PORT_W-1:0] h, s, v, input logic fend);
		result_t             batch[2*BOX_LIM];
		logic [BOUNDS_W-1:0] p;
		int                  n, nb, w, r, c;
		n = 0;
		w = (m_width == 0) ? 1 :
			(m_width > hmrc_pkg::MAX_ROWS) ? int'(hmrc_pkg::MAX_ROWS) : int'(m_width);
		nb = (m_range > BOX_LIM) ? BOX_LIM : int'(m_range);
		r = int'(row_cnt);
		c = int'(col_cnt);
		px_cnt = bump(px_cnt);
		for (int b = 0; b < nb; b++) begin
			p = m_bounds[b];
			if (in_window(h, p, 0) && in_window(s, p, 2) && (!m_check || in_window(v, p, 4))) begin
				hit_cnt[b] = bump(hit_cnt[b]);
				batch[n] = {hmrc_pkg::KIND_MATCH, BOX_IDX_W'(b), ROW_W'(r + 1), COL_W'(c + 1),
					CNT_W'(0), CNT_W'(0), 1'b0};
				n++;
			end
		end
		if (fend) begin
			for (int b = 0; b < nb; b++) begin
				batch[n] = {hmrc_pkg::KIND_SUMMARY, BOX_IDX_W'(b), ROW_W'(0), COL_W'(0),
					hit_cnt[b], px_cnt, 1'b0};
				n++;
			end
			row_cnt = '0;
			col_cnt = '0;
			hit_cnt = '{default: '0};
			px_cnt = '0;
		end else if (r + 1 >= w) begin
			row_cnt = '0;
			if (c < hmrc_pkg::COL_LIMIT)
				col_cnt = COL_W'(c + 1);
		end else begin
			row_cnt = ROWCNT_W'(r + 1);
		end
		if (n > 0)
			batch[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			awaited_results.insert(awaited_results.size(), batch[i]);
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BOUNDS_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			hmrc_pkg::REG_COL_HEIGHT:  m_width = val[ROW_W-1:0];
			hmrc_pkg::REG_CHECK_VALUE: m_check = val[0];
			hmrc_pkg::REG_RANGE_COUNT: m_range = val[RNG_W-1:0];
			default: m_bounds[BOX_IDX_W'(idx - hmrc_pkg::REG_BOX0_BOUNDS)] = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_regs(input int w, input int chk, input int rng,
			input logic [BOUNDS_W-1:0] b0, b1, b2, b3);
		write_reg(hmrc_pkg::REG_COL_HEIGHT, BOUNDS_W'(w));
		write_reg(hmrc_pkg::REG_CHECK_VALUE, BOUNDS_W'(chk));
		write_reg(hmrc_pkg::REG_RANGE_COUNT, BOUNDS_W'(rng));
		write_reg(hmrc_pkg::REG_BOX0_BOUNDS, b0);
		write_reg(IDX_W'(hmrc_pkg::REG_BOX0_BOUNDS + 1), b1);
		write_reg(IDX_W'(hmrc_pkg::REG_BOX0_BOUNDS + 2), b2);
		write_reg(IDX_W'(hmrc_pkg::REG_BOX0_BOUNDS + 3), b3);
	endtask

	task automatic queue_pixel(input int h, s, v, fe);
		pixel_t px;
		px = {COMP_PORT_W'(h), COMP_PORT_W'(s), COMP_PORT_W'(v), 1'(fe)};
		pixel_requests.insert(pixel_requests.size(), px);
	endtask

	// Wait until every request went in and every result came out
	task automatic settle();
		while (pixel_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pick a component on, around or between the bounds of a box
	function automatic logic [COMP_PORT_W-1:0] pick_comp(logic [BOUNDS_W-1:0] p, int slot);
		logic [COMP_PORT_W-1:0] lo, hi;
		lo = bound_of(p, slot);
		hi = bound_of(p, slot + 1);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return lo - 1'b1;
			3: return hi + 1'b1;
			7: return COMP_PORT_W'($urandom);
			default: return (lo <= hi) ? COMP_PORT_W'($urandom_range(lo, hi)) :
				COMP_PORT_W'($urandom);
		endcase
	endfunction

	function automatic logic [BOUNDS_W-1:0] random_box();
		logic [BOUNDS_W-1:0] box;
		int                  pick, a, b;
		box = '0;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return FULL_BOX;
		if (pick == 1)
			return BOUNDS_W'({$urandom, $urandom});
		for (int k = 0; k < 3; k++) begin
			if (pick == 2 && k == 0) begin
				// Empty box: low bound above high bound
				b = $urandom_range(0, COMP_MAX - 1);
				a = $urandom_range(b + 1, COMP_MAX);
			end else begin
				a = $urandom_range(0, COMP_MAX);
				b = a + $urandom_range(0, 700);
				if (b > COMP_MAX)
					b = COMP_MAX;
			end
			box = {box[BOUNDS_W-21:0], 10'(a), 10'(b)};
		end
		return box;
	endfunction

	function automatic int random_width();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 4096;
			2: return $urandom_range(4097, 8191);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int random_range();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return $urandom_range(5, 7);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	// Drive pixel requests in bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_requests.size() > 0) begin
				drv_px = pixel_requests.pop_front();
				hue <= drv_px.h;
				saturation <= drv_px.s;
				brightness <= drv_px.v;
				frame_end <= drv_px.fend;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side: one long hold-off, otherwise a changing pattern
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && pixels_in >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				default:  out_stall <= (rx_cycle % 5) < 2;
			endcase
		end
	end

	// Check each result, then predict for the pixel taken on this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {kind, box_index, row_pos, col_pos, match_count, pixel_total, last};
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual %s", $time, show(got));
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: result mismatch, expected %s, actual %s",
							$time, show(want), show(got));
					end
				end
			end
			if (in_valid && !in_stall) begin
				classify_pixel(hue, saturation, brightness, frame_end);
				pixels_in <= pixels_in + 1;
			end
			in_taken <= in_valid && !in_stall;
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("hsv_multi_range_pixel_classifier test failed");
			$finish;
		end
	end

	initial begin
		logic [BOUNDS_W-1:0] boxes[BOX_LIM];
		logic [BOUNDS_W-1:0] p;
		int                  rng, b;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: width 1, one all-zero box
		queue_pixel(0, 0, 0, 0);
		queue_pixel(1023, 1023, 1023, 0);
		queue_pixel(0, 0, 1, 1);
		settle();

		// Full box, empty box, corner box and a hue band with value zero
		setup_regs(3, 1, 4, FULL_BOX, pack_box(600, 500, 0, 1023, 0, 1023),
			pack_box(1023, 1023, 0, 0, 1023, 1023), pack_box(100, 200, 0, 1023, 0, 0));
		queue_pixel(1023, 0, 1023, 0);
		queue_pixel(150, 512, 0, 0);
		queue_pixel(550, 700, 300, 0);
		queue_pixel(200, 1023, 0, 0);
		queue_pixel(99, 5, 0, 0);
		queue_pixel(201, 5, 0, 1);
		settle();

		// Value ignored, box count above the limit, width zero
		write_reg(hmrc_pkg::REG_CHECK_VALUE, BOUNDS_W'(0));
		write_reg(hmrc_pkg::REG_RANGE_COUNT, BOUNDS_W'(7));
		write_reg(hmrc_pkg::REG_COL_HEIGHT, BOUNDS_W'(0));
		queue_pixel(150, 9, 777, 0);
		queue_pixel(1023, 0, 5, 0);
		queue_pixel(1023, 0, 1023, 1);
		settle();

		// No box in use: frame end still clears the counters
		setup_regs(4096, 1, 0, FULL_BOX, FULL_BOX, FULL_BOX, FULL_BOX);
		queue_pixel(17, 300, 900, 0);
		queue_pixel(512, 512, 512, 0);
		queue_pixel(0, 1023, 0, 1);
		settle();

		// All four boxes hit: the largest burst of results for one pixel
		write_reg(hmrc_pkg::REG_RANGE_COUNT, BOUNDS_W'(4));
		queue_pixel(0, 0, 0, 0);
		queue_pixel(1023, 1023, 1023, 1);
		settle();

		// Point box and a saturation-top box
		setup_regs(2, 1, 2, pack_box(5, 5, 5, 5, 5, 5), pack_box(0, 1023, 1023, 1023, 0, 1023),
			'0, '0);
		queue_pixel(5, 5, 5, 0);
		queue_pixel(5, 1023, 5, 0);
		queue_pixel(4, 5, 5, 0);
		queue_pixel(6, 6, 6, 1);
		settle();

		// Random settings and pixels aimed at the box bounds
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int k = 0; k < BOX_LIM; k++)
				boxes[k] = random_box();
			rng = random_range();
			if (ph == 0) begin
				// Every pixel matches, so the long hold-off backs up the input
				boxes[0] = FULL_BOX;
				rng = 4;
			end
			setup_regs(random_width(), int'($urandom_range(0, 1)), rng,
				boxes[0], boxes[1], boxes[2], boxes[3]);
			repeat (PHASE_PIXELS) begin
				b = $urandom_range(0, BOX_LIM - 1);
				p = m_bounds[b];
				queue_pixel(int'(pick_comp(p, 0)), int'(pick_comp(p, 2)),
					int'(pick_comp(p, 4)), int'($urandom_range(0, 11) == 0));
			end
			settle();
		end

		if (errors == 0)
			$display("hsv_multi_range_pixel_classifier test passed");
		else
			$display("hsv_multi_range_pixel_classifier test failed");
		$finish;
	end

endmodule
